@@ design/wmm_pkg.sv @@
// Shared constants and register codes for the 3x3 window mean and median block.
package wmm_pkg;

	localparam int DEF_MAX_LINE    = 1024;
	localparam int DEF_SAMPLE_BITS = 16;

	// Row position width follows the largest line count.
	localparam int ROW_W          = 12;
	localparam int LINE_COUNT_MAX = 4096;

	// Configuration port.
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int LEN_CFG_W  = 11;
	localparam int CNT_CFG_W  = 13;

	localparam int MIN_EXTENT   = 3;
	localparam int RESET_LENGTH = 1024;
	localparam int RESET_COUNT  = 1024;

	// Window geometry.
	localparam int WIN = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_LENGTH = 2'd0,
		REG_LINE_COUNT  = 2'd1
	} cfg_reg_t;

endpackage

@@ design/wmm_in_if.sv @@
// Sample input channel: valid/ready handshake and one sample per word.
interface wmm_in_if #(
	parameter int SAMPLE_BITS = wmm_pkg::DEF_SAMPLE_BITS
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

@@ design/wmm_out_if.sv @@
// Result channel: valid/ready handshake carrying position, mean, median and frame end.
interface wmm_out_if #(
	parameter int SAMPLE_BITS = wmm_pkg::DEF_SAMPLE_BITS,
	parameter int COL_W       = $clog2(wmm_pkg::DEF_MAX_LINE)
);
	logic                      valid;
	logic                      ready;
	logic [COL_W-1:0]          center_col;
	logic [wmm_pkg::ROW_W-1:0] center_row;
	logic [SAMPLE_BITS-1:0]    mean_value;
	logic [SAMPLE_BITS-1:0]    median_value;
	logic                      last_of_frame;

	modport source(output valid, output center_col, output center_row, output mean_value,
		output median_value, output last_of_frame, input ready);
	modport sink(input valid, input center_col, input center_row, input mean_value,
		input median_value, input last_of_frame, output ready);
endinterface

@@ design/wmm_col_cell.sv @@
// One window column cell: holds a column of three samples, sorts and sums it.
module wmm_col_cell #(
	parameter int SAMPLE_BITS = wmm_pkg::DEF_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   shift_en,
	input  logic [SAMPLE_BITS-1:0] in_top,
	input  logic [SAMPLE_BITS-1:0] in_mid,
	input  logic [SAMPLE_BITS-1:0] in_bot,
	output logic [SAMPLE_BITS-1:0] out_top,
	output logic [SAMPLE_BITS-1:0] out_mid,
	output logic [SAMPLE_BITS-1:0] out_bot,
	output logic [SAMPLE_BITS-1:0] col_lo,
	output logic [SAMPLE_BITS-1:0] col_med,
	output logic [SAMPLE_BITS-1:0] col_hi,
	output logic [SAMPLE_BITS+1:0] col_sum
);

	logic [SAMPLE_BITS-1:0] top_q, mid_q, bot_q;
	logic [SAMPLE_BITS-1:0] x0, x1, y1;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			top_q <= in_top;
			mid_q <= in_mid;
			bot_q <= in_bot;
		end
	end

	assign out_top = top_q;
	assign out_mid = mid_q;
	assign out_bot = bot_q;

	// Three compare-exchanges sort the held column.
	always_comb begin
		if (top_q > mid_q) begin
			x0 = mid_q;
			x1 = top_q;
		end else begin
			x0 = top_q;
			x1 = mid_q;
		end
		if (x1 > bot_q) begin
			y1     = bot_q;
			col_hi = x1;
		end else begin
			y1     = x1;
			col_hi = bot_q;
		end
		if (x0 > y1) begin
			col_lo  = y1;
			col_med = x0;
		end else begin
			col_lo  = x0;
			col_med = y1;
		end
	end

	assign col_sum = {2'b00, top_q} + {2'b00, mid_q} + {2'b00, bot_q};

endmodule

@@ design/wmm_reduce.sv @@
// Reduction pipeline: median of nine from three sorted columns, and sum divided by nine.
module wmm_reduce #(
	parameter int SAMPLE_BITS = wmm_pkg::DEF_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [SAMPLE_BITS-1:0] col_lo  [wmm_pkg::WIN],
	input  logic [SAMPLE_BITS-1:0] col_med [wmm_pkg::WIN],
	input  logic [SAMPLE_BITS-1:0] col_hi  [wmm_pkg::WIN],
	input  logic [SAMPLE_BITS+1:0] col_sum [wmm_pkg::WIN],
	output logic [SAMPLE_BITS-1:0] mean_value,
	output logic [SAMPLE_BITS-1:0] median_value
);

	localparam int SUM_W  = SAMPLE_BITS + 4;
	localparam int SHIFT  = SUM_W + 4;
	localparam int PROD_W = SUM_W + SHIFT;
	// ceil(2^SHIFT / 9): exact floor division by nine for any SUM_W-bit sum
	localparam logic [PROD_W-1:0] RECIP = PROD_W'(((128'd1 << SHIFT) + 128'd8) / 128'd9);

	logic [SAMPLE_BITS-1:0] lo_s3  [wmm_pkg::WIN];
	logic [SAMPLE_BITS-1:0] med_s3 [wmm_pkg::WIN];
	logic [SAMPLE_BITS-1:0] hi_s3  [wmm_pkg::WIN];
	logic [SAMPLE_BITS+1:0] sum_s3 [wmm_pkg::WIN];

	logic [SAMPLE_BITS-1:0] lomax_s4, medmed_s4, himin_s4;
	logic [SUM_W-1:0]       sum_s4;

	logic [SAMPLE_BITS-1:0] median_s5;
	logic [PROD_W-1:0]      prod_s5;

	function automatic logic [SAMPLE_BITS-1:0] max2(input logic [SAMPLE_BITS-1:0] a,
		input logic [SAMPLE_BITS-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] min2(input logic [SAMPLE_BITS-1:0] a,
		input logic [SAMPLE_BITS-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] med3(input logic [SAMPLE_BITS-1:0] a,
		input logic [SAMPLE_BITS-1:0] b, input logic [SAMPLE_BITS-1:0] c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3  <= col_lo;
			med_s3 <= col_med;
			hi_s3  <= col_hi;
			sum_s3 <= col_sum;

			// Median of nine is the median of max-of-lows, median-of-mids, min-of-highs.
			lomax_s4  <= max2(max2(lo_s3[0], lo_s3[1]), lo_s3[2]);
			medmed_s4 <= med3(med_s3[0], med_s3[1], med_s3[2]);
			himin_s4  <= min2(min2(hi_s3[0], hi_s3[1]), hi_s3[2]);
			sum_s4    <= SUM_W'(sum_s3[0]) + SUM_W'(sum_s3[1]) + SUM_W'(sum_s3[2]);

			median_s5 <= med3(lomax_s4, medmed_s4, himin_s4);
			prod_s5   <= PROD_W'(sum_s4) * RECIP;
		end
	end

	assign median_value = median_s5;
	assign mean_value   = prod_s5[SHIFT +: SAMPLE_BITS];

endmodule

@@ design/window_mean_median_3x3.sv @@
// Top level: raster 3x3 window with line stores, column cell chain, mean and median outputs.
// Pipeline: a result reaches the output register through memory read, window shift and
// three reduction stages after the sample that completes its window is accepted.
// Throughput: one sample per clock while the result side takes words; the whole pipeline
// holds together when the output word is not taken.
// Reset: arst_n clears valid bits, position counters and restores line_length and line_count
// to 1024, length clipped to MAX_LINE; line stores and window contents are left as they are.
module window_mean_median_3x3 #(
	parameter int MAX_LINE    = wmm_pkg::DEF_MAX_LINE,
	parameter int SAMPLE_BITS = wmm_pkg::DEF_SAMPLE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wmm_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [wmm_pkg::CFG_DATA_W-1:0]   cfg_data,
	wmm_in_if.sink                           pixels,
	wmm_out_if.source                        results
);

	localparam int COL_W = $clog2(MAX_LINE);
	localparam int ROW_W = wmm_pkg::ROW_W;
	localparam int WIN   = wmm_pkg::WIN;

	// Reset extents, clipped into the legal range like any written value.
	localparam int RST_LEN = (wmm_pkg::RESET_LENGTH > MAX_LINE) ? MAX_LINE
		: wmm_pkg::RESET_LENGTH;
	localparam logic [COL_W-1:0] RST_LEN_LAST = COL_W'(RST_LEN - 1);
	localparam logic [ROW_W-1:0] RST_CNT_LAST = ROW_W'(wmm_pkg::RESET_COUNT - 1);
	localparam logic [wmm_pkg::CNT_CFG_W-1:0] MIN_EXT = wmm_pkg::CNT_CFG_W'(wmm_pkg::MIN_EXTENT);
	localparam logic [wmm_pkg::CNT_CFG_W-1:0] MAX_LEN = wmm_pkg::CNT_CFG_W'(MAX_LINE);
	localparam logic [wmm_pkg::CNT_CFG_W-1:0] MAX_CNT =
		wmm_pkg::CNT_CFG_W'(wmm_pkg::LINE_COUNT_MAX);

	// ---------------- configuration ----------------
	// Keep the last column and last row index rather than the extents themselves.
	logic [COL_W-1:0] len_last_q;
	logic [ROW_W-1:0] cnt_last_q;
	logic [COL_W-1:0] len_last_d;
	logic [ROW_W-1:0] cnt_last_d;
	logic [wmm_pkg::CNT_CFG_W-1:0] len_req, cnt_req;

	assign len_req = wmm_pkg::CNT_CFG_W'(cfg_data[wmm_pkg::LEN_CFG_W-1:0]);
	assign cnt_req = cfg_data[wmm_pkg::CNT_CFG_W-1:0];

	// Saturate requested extents into 3..MAX_LINE and 3..4096.
	always_comb begin
		if (len_req < MIN_EXT) begin
			len_last_d = COL_W'(wmm_pkg::MIN_EXTENT - 1);
		end else if (len_req > MAX_LEN) begin
			len_last_d = COL_W'(MAX_LINE - 1);
		end else begin
			len_last_d = COL_W'(len_req - 1'b1);
		end
		if (cnt_req < MIN_EXT) begin
			cnt_last_d = ROW_W'(wmm_pkg::MIN_EXTENT - 1);
		end else if (cnt_req > MAX_CNT) begin
			cnt_last_d = ROW_W'(wmm_pkg::LINE_COUNT_MAX - 1);
		end else begin
			cnt_last_d = ROW_W'(cnt_req - 1'b1);
		end
	end

	// ---------------- handshake ----------------
	// Advance every stage whenever the output register is empty or being emptied.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic adv, acc, cfg_hit;

	assign adv          = !vld_s5 || results.ready;
	assign pixels.ready = adv;
	assign acc          = pixels.valid && adv;

	always_comb begin
		case (wmm_pkg::cfg_reg_t'(cfg_idx))
			wmm_pkg::REG_LINE_LENGTH: cfg_hit = cfg_we;
			wmm_pkg::REG_LINE_COUNT:  cfg_hit = cfg_we;
			default:                  cfg_hit = 1'b0;
		endcase
	end

	// ---------------- position counters ----------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_last_q <= RST_LEN_LAST;
			cnt_last_q <= RST_CNT_LAST;
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg_hit) begin
			// A register write restarts the frame.
			if (wmm_pkg::cfg_reg_t'(cfg_idx) == wmm_pkg::REG_LINE_LENGTH) begin
				len_last_q <= len_last_d;
			end else begin
				cnt_last_q <= cnt_last_d;
			end
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_q == len_last_q) begin
				col_q <= '0;
				row_q <= (row_q == cnt_last_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// ---------------- stage 1: line store read ----------------
	logic [SAMPLE_BITS-1:0] line_up  [MAX_LINE];
	logic [SAMPLE_BITS-1:0] line_mid [MAX_LINE];

	logic [SAMPLE_BITS-1:0] up_s1, mid_s1, x_s1;
	logic [COL_W-1:0]       col_s1, ccol_s1;
	logic [ROW_W-1:0]       crow_s1;
	logic                   emit_s1, last_s1;

	// Read at accept; write back as the word leaves stage 1.
	// The same column comes round again no sooner than three words later.
	always_ff @(posedge clk) begin
		if (adv) begin
			up_s1   <= line_up[col_q];
			mid_s1  <= line_mid[col_q];
			x_s1    <= pixels.sample;
			col_s1  <= col_q;
			ccol_s1 <= col_q - 1'b1;
			crow_s1 <= row_q - 1'b1;
			emit_s1 <= (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
			last_s1 <= (col_q == len_last_q) && (row_q == cnt_last_q);
		end
		if (adv && vld_s1) begin
			line_up[col_s1]  <= mid_s1;
			line_mid[col_s1] <= x_s1;
		end
	end

	// ---------------- stage 2: window of column cells ----------------
	// Cell WIN-1 is the newest column; each cell hands its column to the left neighbor.
	logic [SAMPLE_BITS-1:0] cell_top [WIN+1];
	logic [SAMPLE_BITS-1:0] cell_mid [WIN+1];
	logic [SAMPLE_BITS-1:0] cell_bot [WIN+1];
	logic [SAMPLE_BITS-1:0] col_lo   [WIN];
	logic [SAMPLE_BITS-1:0] col_med  [WIN];
	logic [SAMPLE_BITS-1:0] col_hi   [WIN];
	logic [SAMPLE_BITS+1:0] col_sum  [WIN];
	logic                   shift_en;

	assign shift_en      = adv && vld_s1;
	assign cell_top[WIN] = up_s1;
	assign cell_mid[WIN] = mid_s1;
	assign cell_bot[WIN] = x_s1;

	for (genvar k = 0; k < WIN; k++) begin : g_cell
		wmm_col_cell #(
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.in_top   (cell_top[k+1]),
			.in_mid   (cell_mid[k+1]),
			.in_bot   (cell_bot[k+1]),
			.out_top  (cell_top[k]),
			.out_mid  (cell_mid[k]),
			.out_bot  (cell_bot[k]),
			.col_lo   (col_lo[k]),
			.col_med  (col_med[k]),
			.col_hi   (col_hi[k]),
			.col_sum  (col_sum[k])
		);
	end

	// Oldest column's raw samples leave the chain unused.
	logic spill_unused;
	assign spill_unused = ^{cell_top[0], cell_mid[0], cell_bot[0]};

	// ---------------- stages 3 to 5: reduction ----------------
	logic [SAMPLE_BITS-1:0] mean_s5, median_s5;

	wmm_reduce #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_reduce (
		.clk          (clk),
		.en           (adv),
		.col_lo       (col_lo),
		.col_med      (col_med),
		.col_hi       (col_hi),
		.col_sum      (col_sum),
		.mean_value   (mean_s5),
		.median_value (median_s5)
	);

	// ---------------- control pipeline ----------------
	logic [COL_W-1:0] ccol_s2, ccol_s3, ccol_s4, ccol_s5;
	logic [ROW_W-1:0] crow_s2, crow_s3, crow_s4, crow_s5;
	logic             last_s2, last_s3, last_s4, last_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= acc;
			// Drop border positions once they have shifted the window.
			vld_s2 <= vld_s1 && emit_s1 && !spill_unused | (vld_s1 && emit_s1);
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ccol_s2 <= ccol_s1;
			crow_s2 <= crow_s1;
			last_s2 <= last_s1;
			ccol_s3 <= ccol_s2;
			crow_s3 <= crow_s2;
			last_s3 <= last_s2;
			ccol_s4 <= ccol_s3;
			crow_s4 <= crow_s3;
			last_s4 <= last_s3;
			ccol_s5 <= ccol_s4;
			crow_s5 <= crow_s4;
			last_s5 <= last_s4;
		end
	end

	// ---------------- output word ----------------
	assign results.valid         = vld_s5;
	assign results.center_col    = ccol_s5;
	assign results.center_row    = crow_s5;
	assign results.mean_value    = mean_s5;
	assign results.median_value  = median_s5;
	assign results.last_of_frame = last_s5;

endmodule

@@ test/wmm_window_checker.sv @@
// Window mean and median predictor that compares every result word of the block.
module wmm_window_checker
	import wmm_pkg::*;
#(
	parameter int MAX_LINE    = DEF_MAX_LINE,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	wmm_in_if                     pixels,
	wmm_out_if                    results,
	output int                    fail_count,
	output int                    pending,
	output int                    result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COL_W    = $clog2(MAX_LINE);
	localparam int WIN_AREA = WIN * WIN;
	localparam int MID_RANK = WIN_AREA / 2;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		sample_t          mean;
		sample_t          median;
		logic             last;
	} window_result_t;

	window_result_t      window_results_q[$];
	sample_t             upper_line[MAX_LINE];
	sample_t             middle_line[MAX_LINE];
	sample_t             win[WIN_AREA];
	int unsigned         col_pos;
	int unsigned         row_pos;
	logic [LEN_CFG_W-1:0] len_reg;
	logic [CNT_CFG_W-1:0] cnt_reg;
	int                  mismatches;
	int                  taken;

	function automatic int unsigned eff_length(input logic [LEN_CFG_W-1:0] v);
		if (v < MIN_EXTENT) return MIN_EXTENT;
		if (v > MAX_LINE) return MAX_LINE;
		return 32'(v);
	endfunction

	function automatic int unsigned eff_count(input logic [CNT_CFG_W-1:0] v);
		if (v < MIN_EXTENT) return MIN_EXTENT;
		if (v > LINE_COUNT_MAX) return LINE_COUNT_MAX;
		return 32'(v);
	endfunction

	function automatic sample_t median_of(input sample_t w[WIN_AREA]);
		sample_t s[WIN_AREA];
		sample_t t;
		s = w;
		for (int i = 0; i < WIN_AREA - 1; i++) begin
			for (int j = 0; j < WIN_AREA - 1 - i; j++) begin
				if (s[j] > s[j+1]) begin
					t = s[j];
					s[j] = s[j+1];
					s[j+1] = t;
				end
			end
		end
		return s[MID_RANK];
	endfunction

	task automatic absorb_sample(input sample_t x);
		int unsigned len;
		int unsigned cnt;
		int unsigned c;
		int unsigned r;
		sample_t up;
		sample_t mid;
		logic [SAMPLE_BITS+3:0] sum;
		window_result_t res;
		len = eff_length(len_reg);
		cnt = eff_count(cnt_reg);
		c = col_pos;
		r = row_pos;
		up = upper_line[c];
		mid = middle_line[c];
		upper_line[c] = mid;
		middle_line[c] = x;
		// shift window left by one column, new column enters on the right
		for (int k = 0; k < WIN; k++) begin
			win[k*WIN+0] = win[k*WIN+1];
			win[k*WIN+1] = win[k*WIN+2];
		end
		win[2] = up;
		win[5] = mid;
		win[8] = x;
		if (c >= 2 && r >= 2) begin
			sum = '0;
			for (int k = 0; k < WIN_AREA; k++) sum += (SAMPLE_BITS+4)'(win[k]);
			res.col    = COL_W'(c - 1);
			res.row    = ROW_W'(r - 1);
			res.mean   = sample_t'(sum / WIN_AREA);
			res.median = median_of(win);
			res.last   = (c == len - 1 && r == cnt - 1);
			window_results_q.push_back(res);
		end
		if (c + 1 >= len) begin
			col_pos = 0;
			row_pos = (r + 1 >= cnt) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result_word();
		window_result_t exp_res;
		if (window_results_q.size() == 0) begin
			$error("result word at col %0d row %0d with no expectation waiting",
				results.center_col, results.center_row);
			mismatches++;
			return;
		end
		exp_res = window_results_q.pop_front();
		compare_field("center_col", 32'(exp_res.col), 32'(results.center_col));
		compare_field("center_row", 32'(exp_res.row), 32'(results.center_row));
		compare_field("mean_value", 32'(exp_res.mean), 32'(results.mean_value));
		compare_field("median_value", 32'(exp_res.median), 32'(results.median_value));
		compare_field("last_of_frame", 32'(exp_res.last), 32'(results.last_of_frame));
	endtask

	initial begin
		mismatches = 0;
		taken = 0;
		for (int i = 0; i < MAX_LINE; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		for (int k = 0; k < WIN_AREA; k++) win[k] = '0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_reg = LEN_CFG_W'(RESET_LENGTH);
			cnt_reg = CNT_CFG_W'(RESET_COUNT);
			col_pos = 0;
			row_pos = 0;
			window_results_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_LINE_LENGTH: begin
						len_reg = cfg_data[LEN_CFG_W-1:0];
						col_pos = 0;
						row_pos = 0;
					end
					REG_LINE_COUNT: begin
						cnt_reg = cfg_data[CNT_CFG_W-1:0];
						col_pos = 0;
						row_pos = 0;
					end
					default: ;
				endcase
			end
			if (pixels.valid && pixels.ready) absorb_sample(pixels.sample);
			if (results.valid && results.ready) begin
				check_result_word();
				taken++;
			end
		end
		pending      <= window_results_q.size();
		fail_count   <= mismatches;
		result_count <= taken;
	end

endmodule

@@ test/window_mean_median_3x3_tb.sv @@
// Stimulus and verdict for the 3x3 window mean and median block.
module window_mean_median_3x3_tb;
	import wmm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LINE    = DEF_MAX_LINE;
	localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
	// Indexes past the register list; the block must ignore them.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	// Enough to flush the pipeline, plus some slack.
	localparam int DRAIN_CYCLES  = 8;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int CALM_TAIL     = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int result_count;

	// When set, neither side idles.
	bit calm;
	int sent;
	int reg_writes;

	wmm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) pixels();
	wmm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) results();

	window_mean_median_3x3 #(
		.MAX_LINE   (MAX_LINE),
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.pixels  (pixels),
		.results (results)
	);

	wmm_window_checker #(
		.MAX_LINE   (MAX_LINE),
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_window_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.pixels      (pixels),
		.results     (results),
		.fail_count  (fail_count),
		.pending     (pending),
		.result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up long after the slowest legal run would have finished.
	initial begin
		#12ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Result side: take words, but stall in short random bursts unless calm.
	initial begin
		results.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!calm && $urandom_range(0, 7) == 0) begin
				results.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			results.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Present one sample word and hold it until the block takes it. A random gap
	// may come first; valid stays high between back-to-back words.
	task automatic feed_sample(input logic [SAMPLE_BITS-1:0] value);
		if (!calm && $urandom_range(0, 9) == 0) begin
			pixels.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		pixels.valid  <= 1'b1;
		pixels.sample <= value;
		do @(posedge clk); while (!pixels.ready);
		sent++;
	endtask

	// Drop valid and hold off until every predicted result has been taken.
	task automatic pause_for_results();
		pixels.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Bring the block to idle: no expectations left and the pipeline flushed,
	// since samples on the border rows leave nothing to wait for.
	task automatic settle_block();
		pause_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_idx  <= idx;
		cfg_data <= data;
		cfg_we   <= 1'b1;
		@(posedge clk);
		cfg_we   <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// Mix of extremes, near-extremes with ties and full-range values.
	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return SAMPLE_BITS'($urandom_range(0, 3));
			3: return SAMPLE_BITS'({SAMPLE_BITS{1'b1}} - $urandom_range(0, 3));
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	function automatic int clamp_extent(input int v, input int hi);
		if (v < MIN_EXTENT) return MIN_EXTENT;
		if (v > hi) return hi;
		return v;
	endfunction

	initial begin
		int cur_len;
		int cur_cnt;
		int len_pick;
		int cnt_pick;
		int frame;
		int n_items;
		int random_sent;
		int waited;

		calm        = 1'b1;
		sent        = 0;
		reg_writes  = 0;
		random_sent = 0;
		cur_len     = RESET_LENGTH;
		cur_cnt     = RESET_COUNT;

		arst_n        = 1'b0;
		cfg_we       <= 1'b0;
		cfg_idx      <= REG_LINE_LENGTH;
		cfg_data     <= '0;
		pixels.valid <= 1'b0;
		pixels.sample <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: smallest frame, all-zero window then all-ones window.
		write_reg(REG_LINE_LENGTH, CFG_DATA_W'(MIN_EXTENT));
		write_reg(REG_LINE_COUNT, CFG_DATA_W'(MIN_EXTENT));
		repeat (9) feed_sample('0);
		repeat (9) feed_sample('1);
		settle_block();

		// Out-of-range values saturate up to the minimum extent; spare indexes
		// change nothing.
		write_reg(REG_LINE_LENGTH, '0);
		write_reg(REG_LINE_COUNT, CFG_DATA_W'(MIN_EXTENT - 1));
		write_reg(REG_SPARE_A, '1);
		for (int k = 0; k < 4; k++) feed_sample(SAMPLE_BITS'(k * 16'h2AAB));
		// A spare-index write in mid-frame must not restart the frame.
		settle_block();
		write_reg(REG_SPARE_B, '0);
		for (int k = 4; k < 9; k++) feed_sample(SAMPLE_BITS'(k * 16'h2AAB));
		settle_block();
		cur_len = MIN_EXTENT;
		cur_cnt = MIN_EXTENT;

		// Random phases: new settings, then one or more whole frames and part of another when
		// they are small, or a partial frame when they are large.
		while (random_sent < RANDOM_ITEMS) begin
			calm = (random_sent >= RANDOM_ITEMS - CALM_TAIL) || ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0: len_pick = $urandom_range(0, MIN_EXTENT - 1);
				1: len_pick = MAX_LINE;
				2: len_pick = $urandom_range(MAX_LINE + 1, (1 << LEN_CFG_W) - 1);
				3: len_pick = $urandom_range(13, 64);
				default: len_pick = $urandom_range(MIN_EXTENT, 12);
			endcase
			case ($urandom_range(0, 9))
				0: cnt_pick = $urandom_range(0, MIN_EXTENT - 1);
				1: cnt_pick = LINE_COUNT_MAX;
				2: cnt_pick = $urandom_range(LINE_COUNT_MAX + 1, (1 << CNT_CFG_W) - 1);
				3: cnt_pick = $urandom_range(9, 40);
				default: cnt_pick = $urandom_range(MIN_EXTENT, 8);
			endcase
			// Sometimes keep one register, sometimes poke a spare index.
			if ($urandom_range(0, 3) != 0) begin
				write_reg(REG_LINE_LENGTH, CFG_DATA_W'(len_pick));
				cur_len = clamp_extent(len_pick, MAX_LINE);
			end
			if ($urandom_range(0, 3) != 0) begin
				write_reg(REG_LINE_COUNT, CFG_DATA_W'(cnt_pick));
				cur_cnt = clamp_extent(cnt_pick, LINE_COUNT_MAX);
			end
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					CFG_DATA_W'($urandom()));

			frame = cur_len * cur_cnt;
			if (frame <= 300)
				n_items = frame * $urandom_range(1, 3) + $urandom_range(0, frame - 1);
			else
				n_items = $urandom_range(40, 300);

			for (int i = 0; i < n_items; i++) begin
				// Hold off in mid-frame now and then until all results are out.
				if (i == n_items / 2 && $urandom_range(0, 2) == 0) pause_for_results();
				feed_sample(pick_sample());
			end
			random_sent += n_items;
			settle_block();
		end

		// Final drain, bounded so a lost result shows up as leftovers.
		calm = 1'b1;
		pixels.valid <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d sample words and %0d result words over %0d register writes,",
			sent, result_count, reg_writes);
		$display("with saturated extents, spare-index writes and both stall directions.");
		if (pending != 0)
			$error("%0d expected results left over at the end", pending);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
